>>> src/e2r_pkg.sv
package e2r_pkg;

    localparam int ANGLE_W = 16;
    localparam int ENTRY_W = 16;
    localparam int WORK_FRAC = 30;
    localparam int WORK_W = 34;

    localparam logic signed [WORK_W-1:0] Q30_PI = 34'sd3373259426;
    localparam logic signed [WORK_W-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [WORK_W-1:0] Q30_GAIN = 34'sh026DD3B6A;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle_first;
        logic signed [ANGLE_W-1:0] angle_second;
        logic signed [ANGLE_W-1:0] angle_third;
    } t_in_item;

    typedef struct packed {
        logic signed [ENTRY_W-1:0] m_row0_col0;
        logic signed [ENTRY_W-1:0] m_row0_col1;
        logic signed [ENTRY_W-1:0] m_row0_col2;
        logic signed [ENTRY_W-1:0] m_row1_col0;
        logic signed [ENTRY_W-1:0] m_row1_col1;
        logic signed [ENTRY_W-1:0] m_row1_col2;
        logic signed [ENTRY_W-1:0] m_row2_col0;
        logic signed [ENTRY_W-1:0] m_row2_col1;
        logic signed [ENTRY_W-1:0] m_row2_col2;
    } t_out_item;

    function automatic logic signed [WORK_W-1:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0: v = 32'h3243F6A8;
            5'd1: v = 32'h1DAC6705;
            5'd2: v = 32'h0FADBAFC;
            5'd3: v = 32'h07F56EA6;
            5'd4: v = 32'h03FEAB76;
            5'd5: v = 32'h01FFD55B;
            5'd6: v = 32'h00FFFAAA;
            5'd7: v = 32'h007FFF55;
            5'd8: v = 32'h003FFFEA;
            5'd9: v = 32'h001FFFFD;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001;
            5'd31: v = 32'h00000000;
            default: v = (32'h40000000 >> i) - 32'd1;
        endcase
        return $signed({2'b00, v});
    endfunction

endpackage

>>> src/e2r_cordic_stage.sv
module e2r_cordic_stage #(
    parameter int STAGE = 0,
    parameter int WORK_W = 34
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [WORK_W-1:0] i_x,
    input  logic signed [WORK_W-1:0] i_y,
    input  logic signed [WORK_W-1:0] i_z,
    output logic signed [WORK_W-1:0] o_x,
    output logic signed [WORK_W-1:0] o_y,
    output logic signed [WORK_W-1:0] o_z
);

    localparam logic signed [WORK_W-1:0] ATAN = e2r_pkg::atan_q30(5'(STAGE));

    logic signed [WORK_W-1:0] r_x, r_y, r_z;
    logic signed [WORK_W-1:0] n_x, n_y, n_z;

    always_comb begin
        if (!i_z[WORK_W-1]) begin
            n_x = i_x - (i_y >>> STAGE);
            n_y = i_y + (i_x >>> STAGE);
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + (i_y >>> STAGE);
            n_y = i_y - (i_x >>> STAGE);
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

>>> src/e2r_cos_sin.sv
module e2r_cos_sin #(
    parameter int ANGLE_WIDTH = 16,
    parameter int CORDIC_STAGES = 14,
    parameter int WORK_W = 34
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle,
    output logic signed [WORK_W-1:0]      o_cos,
    output logic signed [WORK_W-1:0]      o_sin
);

    localparam int SHIFT = 30 - (ANGLE_WIDTH - 3);

    logic signed [WORK_W-1:0] r_z0;
    logic signed [WORK_W-1:0] n_z0;
    logic                     n_flip;
    logic [CORDIC_STAGES:0]   r_flip;
    logic signed [WORK_W-1:0] w_x [CORDIC_STAGES+1];
    logic signed [WORK_W-1:0] w_y [CORDIC_STAGES+1];
    logic signed [WORK_W-1:0] w_z [CORDIC_STAGES+1];
    logic signed [WORK_W-1:0] r_cos, r_sin;

    always_comb begin
        logic signed [WORK_W-1:0] z;
        z = WORK_W'(i_angle) <<< SHIFT;
        n_z0 = z;
        n_flip = 1'b0;
        if (z > e2r_pkg::Q30_HALF_PI) begin
            n_z0 = z - e2r_pkg::Q30_PI;
            n_flip = 1'b1;
        end else if (z < -e2r_pkg::Q30_HALF_PI) begin
            n_z0 = z + e2r_pkg::Q30_PI;
            n_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z0 <= n_z0;
            r_flip <= {r_flip[CORDIC_STAGES-1:0], n_flip};
            r_cos <= r_flip[CORDIC_STAGES] ? -w_x[CORDIC_STAGES] : w_x[CORDIC_STAGES];
            r_sin <= r_flip[CORDIC_STAGES] ? -w_y[CORDIC_STAGES] : w_y[CORDIC_STAGES];
        end
    end

    assign w_x[0] = e2r_pkg::Q30_GAIN;
    assign w_y[0] = '0;
    assign w_z[0] = r_z0;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
        e2r_cordic_stage #(.STAGE(g), .WORK_W(WORK_W)) u_stage (
            .i_clk(i_clk), .i_en(i_en),
            .i_x(w_x[g]), .i_y(w_y[g]), .i_z(w_z[g]),
            .o_x(w_x[g+1]), .o_y(w_y[g+1]), .o_z(w_z[g+1])
        );
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

>>> src/e2r_matrix.sv
module e2r_matrix #(
    parameter int ENTRY_WIDTH = 16,
    parameter int WORK_W = 34
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [WORK_W-1:0]      i_c1, i_s1, i_c2, i_s2, i_c3, i_s3,
    output logic signed [ENTRY_WIDTH-1:0] o_m [9]
);

    localparam int SH = 30 - (ENTRY_WIDTH - 2);
    localparam int PW = 2 * WORK_W;

    function automatic logic signed [WORK_W-1:0] mul30(
        input logic signed [WORK_W-1:0] a, input logic signed [WORK_W-1:0] b);
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(b);
        return WORK_W'(p >>> 30);
    endfunction

    function automatic logic signed [ENTRY_WIDTH-1:0] to_entry(
        input logic signed [WORK_W+1:0] v);
        logic signed [WORK_W+1:0] r, one;
        one = (WORK_W+2)'(1) <<< (ENTRY_WIDTH - 2);
        r = v;
        if (SH > 0) r = (v + ((WORK_W+2)'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
        if (r > one) r = one;
        if (r < -one) r = -one;
        return ENTRY_WIDTH'(r);
    endfunction

    logic signed [WORK_W-1:0] r_s1s2, r_c1s2;
    logic signed [WORK_W-1:0] r_c1, r_s1, r_c2, r_s2, r_c3, r_s3;
    logic signed [WORK_W-1:0] r_p [12];
    logic signed [WORK_W-1:0] r_ms2;
    logic signed [ENTRY_WIDTH-1:0] r_m [9];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1s2 <= mul30(i_s1, i_s2);
            r_c1s2 <= mul30(i_c1, i_s2);
            r_c1 <= i_c1; r_s1 <= i_s1; r_c2 <= i_c2;
            r_s2 <= i_s2; r_c3 <= i_c3; r_s3 <= i_s3;

            r_p[0]  <= mul30(r_c2, r_c3);
            r_p[1]  <= mul30(r_c2, r_s3);
            r_p[2]  <= mul30(r_c1, r_s3);
            r_p[3]  <= mul30(r_s1s2, r_c3);
            r_p[4]  <= mul30(r_c1, r_c3);
            r_p[5]  <= mul30(r_s1s2, r_s3);
            r_p[6]  <= mul30(r_s1, r_c2);
            r_p[7]  <= mul30(r_s1, r_s3);
            r_p[8]  <= mul30(r_c1s2, r_c3);
            r_p[9]  <= mul30(r_s1, r_c3);
            r_p[10] <= mul30(r_c1s2, r_s3);
            r_p[11] <= mul30(r_c1, r_c2);
            r_ms2 <= -r_s2;

            r_m[0] <= to_entry((WORK_W+2)'(r_p[0]));
            r_m[1] <= to_entry((WORK_W+2)'(r_p[1]));
            r_m[2] <= to_entry((WORK_W+2)'(r_ms2));
            r_m[3] <= to_entry((WORK_W+2)'(r_p[3]) - (WORK_W+2)'(r_p[2]));
            r_m[4] <= to_entry((WORK_W+2)'(r_p[4]) + (WORK_W+2)'(r_p[5]));
            r_m[5] <= to_entry((WORK_W+2)'(r_p[6]));
            r_m[6] <= to_entry((WORK_W+2)'(r_p[7]) + (WORK_W+2)'(r_p[8]));
            r_m[7] <= to_entry((WORK_W+2)'(r_p[10]) - (WORK_W+2)'(r_p[9]));
            r_m[8] <= to_entry((WORK_W+2)'(r_p[11]));
        end
    end

    assign o_m = r_m;

endmodule

>>> src/euler_to_rotation_matrix_unit.sv
// Converts three Euler angles (signed 16-bit, 13 fraction bits) into the nine entries of the
// 3x3 rotation matrix, row-major, signed 16-bit with 14 fraction bits, saturated at plus or
// minus one. Every item is a fully pipelined pass: one item per cycle is accepted while no
// stall is raised, and each result passes through the angle reduction register, the CORDIC
// stage chain, the sign restore register and the three multiply and rounding stages. A
// stall halts the whole pipe.
module euler_to_rotation_matrix_unit #(
    parameter int CORDIC_STAGES = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  e2r_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output e2r_pkg::t_out_item  o_item
);

    localparam int ANGLE_WIDTH = e2r_pkg::ANGLE_W;
    localparam int ENTRY_WIDTH = e2r_pkg::ENTRY_W;
    localparam int WORK_W = e2r_pkg::WORK_W;
    localparam int LAT = CORDIC_STAGES + 5;

    logic              w_en;
    logic [LAT-1:0]    r_vld;
    logic signed [WORK_W-1:0] w_c [3];
    logic signed [WORK_W-1:0] w_s [3];
    logic signed [ENTRY_WIDTH-1:0] w_m [9];
    logic signed [ANGLE_WIDTH-1:0] w_a [3];

    assign w_en = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    assign w_a[0] = i_item.angle_first;
    assign w_a[1] = i_item.angle_second;
    assign w_a[2] = i_item.angle_third;

    for (genvar g = 0; g < 3; g++) begin : g_cs
        e2r_cos_sin #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES),
            .WORK_W(WORK_W)) u_cs (
            .i_clk(i_clk), .i_en(w_en), .i_angle(w_a[g]),
            .o_cos(w_c[g]), .o_sin(w_s[g])
        );
    end

    e2r_matrix #(.ENTRY_WIDTH(ENTRY_WIDTH), .WORK_W(WORK_W)) u_mat (
        .i_clk(i_clk), .i_en(w_en),
        .i_c1(w_c[0]), .i_s1(w_s[0]), .i_c2(w_c[1]), .i_s2(w_s[1]),
        .i_c3(w_c[2]), .i_s3(w_s[2]),
        .o_m(w_m)
    );

    assign o_valid = r_vld[LAT-1];
    assign o_item.m_row0_col0 = w_m[0];
    assign o_item.m_row0_col1 = w_m[1];
    assign o_item.m_row0_col2 = w_m[2];
    assign o_item.m_row1_col0 = w_m[3];
    assign o_item.m_row1_col1 = w_m[4];
    assign o_item.m_row1_col2 = w_m[5];
    assign o_item.m_row2_col0 = w_m[6];
    assign o_item.m_row2_col1 = w_m[7];
    assign o_item.m_row2_col2 = w_m[8];

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("result item changed under stall");
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall without a waiting result item");
    a_valid_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall && !i_valid |=> !r_vld[0])
        else $error("phantom item entered pipeline");

endmodule
